FILE: rtl/tfst_pkg.sv
// ============================================================================
// Touch frame slot tracker package
// Result kinds, controller states and record field widths.
// ============================================================================
`default_nettype none

package tfst_pkg;

  // Kind of one result transaction, carried on the master tuser.
  typedef enum logic [1:0] {
    KIND_CONTACT = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SYNC    = 2'd2
  } kind_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SYNC = 3'b100
  } state_e;

  // Register indexes on the configuration channel.
  localparam logic CFG_FINGER_COUNT  = 1'b0;
  localparam logic CFG_REPORTING_OFF = 1'b1;

  // Status code of an empty finger record.
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  localparam int unsigned SlotW  = 5;
  localparam int unsigned CoordW = 12;
  localparam int unsigned PressW = 8;
  localparam int unsigned SlotN  = 32;

endpackage

`default_nettype wire

FILE: rtl/touch_frame_slot_tracker_core.sv
// ============================================================================
// Touch frame slot tracker core
// Decodes finger records into contact results, tracks active slots per frame
// and reports releases and a closing frame sync after each frame.
// ============================================================================
// A contact result is registered and valid in the cycle after its record transaction.
// Throughput: one record per cycle while results are taken at once.
// End of frame: the release scan walks one slot per cycle over the effective
//   finger count, holding while a release waits for the output register,
//   then loads the sync; during the scan and the sync no record is accepted.
// Reset: finger count 10, reporting on, both slot masks and the record index
//   cleared, no result pending.
`default_nettype none

module touch_frame_slot_tracker_core #(
  parameter int unsigned MAX_RECORDS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_data_i,
  // Record stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] slot_status, [15:8] x_high, [23:16] y_high, [31:24] xy_low,
  // [39:32] touch_pressure
  input  wire logic [39:0] s_axis_tdata_i,
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [4:0] slot_id, [16:5] x_pos, [28:17] y_pos, [36:29] pressure_out,
  // [39:37] zero
  output logic [39:0]      m_axis_tdata_o,
  // [1:0] report_kind
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  import tfst_pkg::*;

  localparam logic [4:0] MaxRec = 5'(MAX_RECORDS);

  // Configuration registers
  logic [4:0] finger_count_q;
  logic       reporting_off_q;

  // Tracking state
  state_e             state_q, state_d;
  logic [SlotN-1:0]   prev_mask_q, prev_mask_d;
  logic [SlotN-1:0]   frame_mask_q, frame_mask_d;
  logic [4:0]         rec_idx_q, rec_idx_d;
  logic [4:0]         scan_idx_q, scan_idx_d;

  // Output register
  logic               out_vld_q, out_vld_d;
  kind_e              out_kind_q, out_kind_d;
  logic [SlotW-1:0]   out_slot_q, out_slot_d;
  logic [CoordW-1:0]  out_x_q, out_x_d;
  logic [CoordW-1:0]  out_y_q, out_y_d;
  logic [PressW-1:0]  out_p_q, out_p_d;
  logic               out_last_q, out_last_d;

  // Record fields
  logic [7:0]       rec_ids, rec_xh, rec_yh, rec_xyl, rec_pr;
  logic [SlotW-1:0] rec_slot;
  logic             rec_empty;

  logic [4:0] eff_count;
  logic       ends_frame;
  logic       out_free;
  logic       in_fire;
  logic       scan_hit;
  logic       scan_done;

  assign rec_ids   = s_axis_tdata_i[7:0];
  assign rec_xh    = s_axis_tdata_i[15:8];
  assign rec_yh    = s_axis_tdata_i[23:16];
  assign rec_xyl   = s_axis_tdata_i[31:24];
  assign rec_pr    = s_axis_tdata_i[39:32];
  assign rec_slot  = rec_ids[7:3];
  assign rec_empty = (rec_ids[1:0] == STATUS_EMPTY);

  // Clamp the finger count to 1..MAX_RECORDS.
  always_comb begin
    if (finger_count_q == 5'd0) begin
      eff_count = 5'd1;
    end else if (finger_count_q > MaxRec) begin
      eff_count = MaxRec;
    end else begin
      eff_count = finger_count_q;
    end
  end

  assign ends_frame = ({1'b0, rec_idx_q} + 6'd1) >= {1'b0, eff_count};

  // The output register can take a new result when empty or being drained.
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Release test for the slot under the scan pointer.
  assign scan_hit  = prev_mask_q[scan_idx_q] && !frame_mask_q[scan_idx_q];
  assign scan_done = ({1'b0, scan_idx_q} + 6'd1) >= {1'b0, eff_count};

  // Sequencer: accept records, walk the release scan, close with a sync.
  always_comb begin
    state_d      = state_q;
    prev_mask_d  = prev_mask_q;
    frame_mask_d = frame_mask_q;
    rec_idx_d    = rec_idx_q;
    scan_idx_d   = scan_idx_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_kind_d   = out_kind_q;
    out_slot_d   = out_slot_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_p_d      = out_p_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && !reporting_off_q) begin
          if (!rec_empty) begin
            out_vld_d              = 1'b1;
            out_kind_d             = KIND_CONTACT;
            out_slot_d             = rec_slot;
            out_x_d                = {rec_xh, rec_xyl[7:4]};
            out_y_d                = {rec_yh, rec_xyl[3:0]};
            out_p_d                = rec_pr;
            out_last_d             = !ends_frame;
            frame_mask_d[rec_slot] = 1'b1;
          end
          if (ends_frame) begin
            scan_idx_d = 5'd0;
            state_d    = ST_SCAN;
          end else begin
            rec_idx_d = rec_idx_q + 5'd1;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_hit || out_free) begin
          if (scan_hit) begin
            out_vld_d  = 1'b1;
            out_kind_d = KIND_RELEASE;
            out_slot_d = scan_idx_q;
            out_x_d    = '0;
            out_y_d    = '0;
            out_p_d    = '0;
            out_last_d = 1'b0;
          end
          scan_idx_d = scan_idx_q + 5'd1;
          if (scan_done) begin
            state_d = ST_SYNC;
          end
        end
      end
      ST_SYNC: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_kind_d   = KIND_SYNC;
          out_slot_d   = '0;
          out_x_d      = '0;
          out_y_d      = '0;
          out_p_d      = '0;
          out_last_d   = 1'b1;
          prev_mask_d  = frame_mask_q;
          frame_mask_d = '0;
          rec_idx_d    = 5'd0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finger_count_q  <= 5'd10;
      reporting_off_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FINGER_COUNT:  finger_count_q  <= cfg_data_i;
        CFG_REPORTING_OFF: reporting_off_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_mask_q  <= '0;
      frame_mask_q <= '0;
      rec_idx_q    <= 5'd0;
      scan_idx_q   <= 5'd0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_mask_q  <= prev_mask_d;
      frame_mask_q <= frame_mask_d;
      rec_idx_q    <= rec_idx_d;
      scan_idx_q   <= scan_idx_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_p_q    <= out_p_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_p_q, out_y_q, out_x_q, out_slot_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // Records are taken only while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (state_q == ST_IDLE))
    else $error("record accepted outside idle state");

  // A pending sync always closes the frame's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_kind_q == KIND_SYNC)) |-> m_axis_tlast_o)
    else $error("sync result without tlast");

  // Loading the sync rolls the frame over and clears the frame state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SYNC) && out_free) |=>
      ((frame_mask_q == '0) && (rec_idx_q == 5'd0) && (state_q == ST_IDLE)))
    else $error("frame state not cleared after sync");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ============================================================================
// Touch frame slot tracker testbench
// Drives finger records and register writes into the tracker core, predicts
// the contact, release and frame sync results of every accepted record, and
// compares each result transaction field by field in arrival order.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

  import tfst_pkg::*;

  localparam int unsigned MAX_RECORDS    = 20;
  localparam int unsigned RANDOM_RECORDS = 155;
  // Covers the longest end-of-frame scan plus a margin.
  localparam int unsigned SETTLE_CYCLES  = MAX_RECORDS + 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // One result transaction as seen on the master side.
  typedef struct packed {
    kind_e               kind;
    logic [SlotW-1:0]    slot;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [PressW-1:0]   pressure;
    logic                last;
  } tracker_report_t;

  // Tracks slot masks and the record index, and queues the results that
  // each accepted record should cause.
  class frame_report_scoreboard;
    logic [4:0]        finger_count;
    logic              reporting_off;
    logic [SlotN-1:0]  prev_slots;
    logic [SlotN-1:0]  frame_slots;
    logic [4:0]        record_index;
    tracker_report_t   pending_reports[$];
    int unsigned       mismatches;
    int unsigned       contacts;
    int unsigned       releases;
    int unsigned       syncs;

    function new();
      finger_count  = 5'd10;
      reporting_off = 1'b0;
      prev_slots    = '0;
      frame_slots   = '0;
      record_index  = '0;
      mismatches    = 0;
      contacts      = 0;
      releases      = 0;
      syncs         = 0;
    endfunction

    function void write_register(logic index, logic [4:0] value);
      if (index == CFG_FINGER_COUNT) begin
        finger_count = value;
      end else begin
        reporting_off = value[0];
      end
    endfunction

    function void push_report(kind_e kind, logic [4:0] slot, logic [11:0] x,
                              logic [11:0] y, logic [7:0] pressure, logic last);
      tracker_report_t r;
      r.kind     = kind;
      r.slot     = slot;
      r.x        = x;
      r.y        = y;
      r.pressure = pressure;
      r.last     = last;
      pending_reports.push_back(r);
    endfunction

    function void take_record(logic [39:0] rec);
      logic [7:0]  slot_status;
      logic [7:0]  xy_low;
      logic [4:0]  slot;
      int unsigned count;
      logic        ends_frame;
      slot_status = rec[7:0];
      xy_low      = rec[31:24];
      slot        = slot_status[7:3];
      // Records are dropped without any state change while reporting is off.
      if (reporting_off) return;
      count = finger_count;
      if (count < 1) count = 1;
      if (count > MAX_RECORDS) count = MAX_RECORDS;
      ends_frame = (int'(record_index) + 1) >= count;
      if (slot_status[1:0] != STATUS_EMPTY) begin
        push_report(KIND_CONTACT, slot, {rec[15:8], xy_low[7:4]},
                    {rec[23:16], xy_low[3:0]}, rec[39:32], !ends_frame);
        frame_slots[slot] = 1'b1;
      end
      if (!ends_frame) begin
        record_index = record_index + 5'd1;
        return;
      end
      // Release every scanned slot that was active last frame and is gone now.
      for (int i = 0; i < count; i++) begin
        if (prev_slots[i] && !frame_slots[i]) begin
          push_report(KIND_RELEASE, 5'(i), '0, '0, '0, 1'b0);
        end
      end
      push_report(KIND_SYNC, '0, '0, '0, '0, 1'b1);
      prev_slots   = frame_slots;
      frame_slots  = '0;
      record_index = '0;
    endfunction

    function void compare_report(tracker_report_t got);
      tracker_report_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: kind %0d slot %0d x %0d y %0d pressure %0d last %0d",
                   got.kind, got.slot, got.x, got.y, got.pressure, got.last);
        end
        return;
      end
      want = pending_reports.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot || got.x !== want.x ||
          got.y !== want.y || got.pressure !== want.pressure || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected kind %0d slot %0d x %0d y %0d pressure %0d last %0d",
                   want.kind, want.slot, want.x, want.y, want.pressure, want.last);
          $display("          actual   kind %0d slot %0d x %0d y %0d pressure %0d last %0d",
                   got.kind, got.slot, got.x, got.y, got.pressure, got.last);
        end
      end else begin
        case (want.kind)
          KIND_CONTACT: contacts++;
          KIND_RELEASE: releases++;
          default:      syncs++;
        endcase
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  frame_report_scoreboard sb;

  // Pacing controls for the stimulus and the result sink, and the idle counter.
  bit          src_eager;
  bit          sink_eager;
  bit          hold_request;
  int unsigned idle_cycles;

  touch_frame_slot_tracker_core #(
    .MAX_RECORDS(MAX_RECORDS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor: checks results, feeds accepted records and register writes to
  // the scoreboard, and ends a run in which no transaction happens any more.
  always @(posedge clk_i) begin : monitor
    tracker_report_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind     = kind_e'(m_axis_tuser_o);
        got.slot     = m_axis_tdata_o[4:0];
        got.x        = m_axis_tdata_o[16:5];
        got.y        = m_axis_tdata_o[28:17];
        got.pressure = m_axis_tdata_o[36:29];
        got.last     = m_axis_tlast_o;
        sb.compare_report(got);
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.take_record(s_axis_tdata_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_register(cfg_index_i, cfg_data_i);
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result sink: random stalls per result, with an optional long hold-off.
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = sink_eager ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid_o && m_axis_tready_i)) @(posedge clk_i);
    end
  end

  // Builds one finger record; the unused id bit is filled at random.
  function automatic logic [39:0] pack_record(logic [4:0] slot, logic [1:0] status,
                                              logic [11:0] x, logic [11:0] y,
                                              logic [7:0] pressure);
    logic spare;
    spare = 1'($urandom_range(0, 1));
    return {pressure, x[3:0], y[3:0], y[11:4], x[11:4], slot, spare, status};
  endfunction

  // Random record; most slots fall inside the scanned range.
  function automatic logic [39:0] random_record(int unsigned eff);
    logic [4:0] slot;
    if ($urandom_range(0, 4) == 0) begin
      slot = 5'($urandom_range(0, 31));
    end else begin
      slot = 5'($urandom_range(0, eff - 1));
    end
    return pack_record(slot, 2'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                       8'($urandom));
  endfunction

  task automatic send_record(input logic [39:0] rec);
    int unsigned gap;
    gap = src_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rec;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // One register write, with valid dropped again before the task returns.
  task automatic write_register(input logic index, input logic [4:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops sending and waits until every expected result has arrived and any
  // trailing record without a result has been processed.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Main stimulus sequence.
  initial begin : stimulus
    int unsigned random_records;
    int unsigned total_records;
    int unsigned phases;
    int unsigned pick;
    int unsigned eff;
    int unsigned n;
    logic [4:0]  count_cfg;
    logic        off;

    sb = new();
    random_records = 0;
    total_records  = 0;
    phases         = 0;
    idle_cycles    = 0;
    src_eager      = 1'b0;
    sink_eager     = 1'b0;
    hold_request   = 1'b0;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_FINGER_COUNT;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Directed: three-record frames with extreme coordinates, a slot above
    // the count and empty records, followed by releases of missing slots.
    write_register(CFG_FINGER_COUNT, 5'd3);
    send_record(pack_record(5'd0, 2'd0, 12'h000, 12'h000, 8'h00));
    send_record(pack_record(5'd1, 2'd2, 12'hfff, 12'hfff, 8'hff));
    send_record(pack_record(5'd31, 2'd1, 12'h800, 12'h07f, 8'h80));
    send_record(pack_record(5'd0, STATUS_EMPTY, 12'h5a5, 12'ha5a, 8'h55));
    send_record(pack_record(5'd2, 2'd0, 12'h123, 12'hedc, 8'haa));
    send_record(pack_record(5'd31, STATUS_EMPTY, 12'hfff, 12'h000, 8'hff));

    // Directed: partial frame at the largest count, records ignored while
    // reporting is off, then the count lowered so the next record ends it.
    wait_idle();
    write_register(CFG_FINGER_COUNT, 5'd20);
    send_record(pack_record(5'd5, 2'd0, 12'h010, 12'h020, 8'h01));
    send_record(pack_record(5'd19, 2'd1, 12'hff0, 12'h00f, 8'hfe));
    send_record(pack_record(5'd8, STATUS_EMPTY, 12'h000, 12'h000, 8'h00));
    send_record(pack_record(5'd7, 2'd2, 12'h0ff, 12'hf00, 8'h7f));
    wait_idle();
    write_register(CFG_REPORTING_OFF, 5'd1);
    send_record(pack_record(5'd9, 2'd0, 12'hfff, 12'hfff, 8'hff));
    send_record(pack_record(5'd0, STATUS_EMPTY, 12'h000, 12'h000, 8'h00));
    wait_idle();
    write_register(CFG_REPORTING_OFF, 5'd0);
    write_register(CFG_FINGER_COUNT, 5'd1);
    send_record(pack_record(5'd0, 2'd0, 12'h321, 12'h654, 8'h42));

    // Directed: a count of zero behaves as one.
    wait_idle();
    write_register(CFG_FINGER_COUNT, 5'd0);
    send_record(pack_record(5'd4, STATUS_EMPTY, 12'h000, 12'h000, 8'h00));
    send_record(pack_record(5'd3, 2'd1, 12'habc, 12'hdef, 8'h99));
    total_records = 13;

    // Long receiver hold-off while a full frame is pushed back to back.
    wait_idle();
    write_register(CFG_FINGER_COUNT, 5'd20);
    src_eager    = 1'b1;
    hold_request = 1'b1;
    repeat (MAX_RECORDS) send_record(random_record(MAX_RECORDS));
    total_records += MAX_RECORDS;
    src_eager = 1'b0;

    // Random phases, each with its own register setting and pacing.
    while (random_records < RANDOM_RECORDS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       count_cfg = 5'd0;
        1:       count_cfg = 5'd31;
        2:       count_cfg = 5'd20;
        3:       count_cfg = 5'($urandom_range(7, 20));
        default: count_cfg = 5'($urandom_range(1, 6));
      endcase
      eff = (count_cfg == 0) ? 1 : (count_cfg > MAX_RECORDS) ? MAX_RECORDS : count_cfg;
      off = ($urandom_range(0, 5) == 0);
      wait_idle();
      src_eager  = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      write_register(CFG_FINGER_COUNT, count_cfg);
      write_register(CFG_REPORTING_OFF, {4'd0, off});
      if (off) begin
        n = $urandom_range(1, 4);
      end else begin
        n = eff * ((eff > 6) ? 1 : $urandom_range(1, 4));
        // Leave a frame open now and then, so the next setting applies mid-frame.
        if ($urandom_range(0, 2) == 0) n += $urandom_range(0, eff - 1);
      end
      repeat (n) send_record(random_record(eff));
      if (!off) begin
        random_records += n;
        total_records  += n;
      end
      phases++;
    end

    wait_idle();
    $display("Run covered %0d reported records in %0d random phases, finger counts 0 to 31,",
             total_records, phases);
    $display("reporting on and off; checked %0d contacts, %0d releases, %0d syncs.",
             sb.contacts, sb.releases, sb.syncs);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
